FILE: rtl/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swizzled pixel address package
// Shared types and constants: pixel format codes, register indexes, the
// configuration bundle and the result bundle.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int unsigned FORMAT_W   = 4;
  localparam int unsigned BLOCK_W    = 14;
  localparam int unsigned BWIDTH_W   = 6;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned BITOFF_W   = 3;
  localparam int unsigned COLUMN_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // Memory holds 2**BLOCK_W blocks of 256 bytes; block numbers wrap there.
  localparam int unsigned MEMORY_BLOCKS   = 16384;
  localparam int unsigned BYTES_PER_BLOCK = 256;

  localparam logic [FORMAT_W-1:0] FMT_CT32  = 4'd0;
  localparam logic [FORMAT_W-1:0] FMT_CT24  = 4'd1;
  localparam logic [FORMAT_W-1:0] FMT_CT16  = 4'd2;
  localparam logic [FORMAT_W-1:0] FMT_CT16S = 4'd3;
  localparam logic [FORMAT_W-1:0] FMT_T8    = 4'd4;
  localparam logic [FORMAT_W-1:0] FMT_T4    = 4'd5;
  localparam logic [FORMAT_W-1:0] FMT_T8H   = 4'd6;
  localparam logic [FORMAT_W-1:0] FMT_T4HL  = 4'd7;
  localparam logic [FORMAT_W-1:0] FMT_T4HH  = 4'd8;
  localparam logic [FORMAT_W-1:0] FMT_Z32   = 4'd9;
  localparam logic [FORMAT_W-1:0] FMT_Z24   = 4'd10;
  localparam logic [FORMAT_W-1:0] FMT_Z16   = 4'd11;
  localparam logic [FORMAT_W-1:0] FMT_Z16S  = 4'd12;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_BLOCK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH = 2'd2;

  typedef enum logic [2:0] {
    DEPTH_NONE = 3'd0,
    DEPTH_32   = 3'd1,
    DEPTH_16   = 3'd2,
    DEPTH_8    = 3'd3,
    DEPTH_4    = 3'd4
  } depth_t;

  typedef struct packed {
    logic [FORMAT_W-1:0] pixel_format;
    logic [BLOCK_W-1:0]  start_block;
    logic [BWIDTH_W-1:0] buffer_width;
  } cfg_t;

  typedef struct packed {
    logic                address_valid;
    logic [ADDR_W-1:0]   byte_address;
    logic [BITOFF_W-1:0] bit_offset;
    logic [BLOCK_W-1:0]  block_number;
    logic [COLUMN_W-1:0] column_number;
  } result_t;

endpackage : spa_pkg
`default_nettype wire

FILE: rtl/spa_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel coordinate channel
// Valid/ready channel carrying one pixel coordinate per transfer.
// ----------------------------------------------------------------------------
interface spa_pixel_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_x;
  logic [10:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface : spa_pixel_if
`default_nettype wire

FILE: rtl/spa_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address result channel
// Valid/ready channel carrying one pixel address result per transfer.
// ----------------------------------------------------------------------------
interface spa_result_if;
  logic        valid;
  logic        ready;
  logic        address_valid;
  logic [21:0] byte_address;
  logic [2:0]  bit_offset;
  logic [13:0] block_number;
  logic [1:0]  column_number;

  modport source (output valid, output address_valid, output byte_address,
                  output bit_offset, output block_number, output column_number,
                  input ready);
  modport sink   (input valid, input address_valid, input byte_address,
                  input bit_offset, input block_number, input column_number,
                  output ready);
endinterface : spa_result_if
`default_nettype wire

FILE: rtl/swizzled_pixel_address.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swizzled pixel address generator
// Maps a pixel coordinate to its byte, bit, block and column in a tiled
// 4 MiB memory for the configured pixel format, start block and buffer width.
//
// Channels: pixel (sink) takes pixel_x/pixel_y; result (source) gives
// address_valid, byte_address, bit_offset, block_number, column_number.
// Configuration: cfg_write_en with cfg_index 0 pixel_format, 1 start_block,
// 2 buffer_width; other indexes are ignored. Write only while idle.
// Pipeline: input register, then result register; the result register loads
// from the input stage whenever it is free. Throughput: one pixel per cycle
// while result.ready stays high, set by the single pass through page
// multiply, block table and column table between the two registers.
// Reset: configuration clears to zero, both pipeline stages empty.
// Stall: a held result keeps its register; an empty input stage still takes
// one more pixel, then pixel.ready drops until result.ready returns.
// ----------------------------------------------------------------------------
module swizzled_pixel_address
  import spa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  spa_pixel_if.sink                  pixel,
  spa_result_if.source               result
);

  cfg_t                cfg;
  result_t             calc_res;
  logic                in_valid;
  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;
  logic                out_valid;
  result_t             out_res;
  logic                out_free;
  logic                in_free;

  spa_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  spa_addr_calc u_calc (
    .cfg (cfg),
    .x   (in_x),
    .y   (in_y),
    .res (calc_res)
  );

  assign out_free    = !out_valid || result.ready;
  assign in_free     = !in_valid || out_free;
  assign pixel.ready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && pixel.valid) begin
      in_x <= pixel.pixel_x;
      in_y <= pixel.pixel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_res <= calc_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.address_valid = out_res.address_valid;
  assign result.byte_address  = out_res.byte_address;
  assign result.bit_offset    = out_res.bit_offset;
  assign result.block_number  = out_res.block_number;
  assign result.column_number = out_res.column_number;

endmodule : swizzled_pixel_address
`default_nettype wire

FILE: rtl/spa_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Pixel format, start block and buffer width, written by index.
// ----------------------------------------------------------------------------
module spa_cfg_regs
  import spa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [FORMAT_W-1:0] pixel_format;
  logic [BLOCK_W-1:0]  start_block;
  logic [BWIDTH_W-1:0] buffer_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= '0;
      start_block  <= '0;
      buffer_width <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[FORMAT_W-1:0];
        REG_START_BLOCK:  start_block  <= cfg_data[BLOCK_W-1:0];
        REG_BUFFER_WIDTH: buffer_width <= cfg_data[BWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{pixel_format: pixel_format,
                 start_block:  start_block,
                 buffer_width: buffer_width};

endmodule : spa_cfg_regs
`default_nettype wire

FILE: rtl/spa_addr_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address calculation
// Page placement, block table lookup and column swizzle for one pixel.
// ----------------------------------------------------------------------------
module spa_addr_calc
  import spa_pkg::*;
(
  input  wire cfg_t                cfg,
  input  wire logic [COORD_W-1:0]  x,
  input  wire logic [COORD_W-1:0]  y,
  output result_t                  res
);

  localparam logic [7:0] BYTE8 [256] = '{
      0,   4,  16,  20,  32,  36,  48,  52,   8,  12,  24,  28,  40,  44,  56,  60,
      2,   6,  18,  22,  34,  38,  50,  54,  10,  14,  26,  30,  42,  46,  58,  62,
     33,  37,  49,  53,   1,   5,  17,  21,  41,  45,  57,  61,   9,  13,  25,  29,
     35,  39,  51,  55,   3,   7,  19,  23,  43,  47,  59,  63,  11,  15,  27,  31,
     66,  70,  82,  86,  98, 102, 114, 118,  74,  78,  90,  94, 106, 110, 122, 126,
     64,  68,  80,  84,  96, 100, 112, 116,  72,  76,  88,  92, 104, 108, 120, 124,
     99, 103, 115, 119,  67,  71,  83,  87, 107, 111, 123, 127,  75,  79,  91,  95,
     97, 101, 113, 117,  65,  69,  81,  85, 105, 109, 121, 125,  73,  77,  89,  93,
    128, 132, 144, 148, 160, 164, 176, 180, 136, 140, 152, 156, 168, 172, 184, 188,
    130, 134, 146, 150, 162, 166, 178, 182, 138, 142, 154, 158, 170, 174, 186, 190,
    161, 165, 177, 181, 129, 133, 145, 149, 169, 173, 185, 189, 137, 141, 153, 157,
    163, 167, 179, 183, 131, 135, 147, 151, 171, 175, 187, 191, 139, 143, 155, 159,
    194, 198, 210, 214, 226, 230, 242, 246, 202, 206, 218, 222, 234, 238, 250, 254,
    192, 196, 208, 212, 224, 228, 240, 244, 200, 204, 216, 220, 232, 236, 248, 252,
    227, 231, 243, 247, 195, 199, 211, 215, 235, 239, 251, 255, 203, 207, 219, 223,
    225, 229, 241, 245, 193, 197, 209, 213, 233, 237, 249, 253, 201, 205, 217, 221
  };

  depth_t              depth;
  logic [2:0]          bx;
  logic [2:0]          by;
  logic [3:0]          lx;
  logic [3:0]          ly;
  logic [5:0]          page_row;
  logic [4:0]          page_col;
  logic [5:0]          across_raw;
  logic [5:0]          across;
  logic [11:0]         row_base;
  logic [8:0]          page_low;
  logic [4:0]          c32_blk;
  logic [4:0]          c16_blk;
  logic [4:0]          c16s_blk;
  logic [4:0]          blk;
  logic [BLOCK_W-1:0]  block;
  logic [7:0]          byte_off;

  always_comb begin
    case (cfg.pixel_format) inside
      FMT_CT32, FMT_CT24, FMT_T8H, FMT_T4HL, FMT_T4HH, FMT_Z32, FMT_Z24:
        depth = DEPTH_32;
      FMT_CT16, FMT_CT16S, FMT_Z16, FMT_Z16S: depth = DEPTH_16;
      FMT_T8: depth = DEPTH_8;
      FMT_T4: depth = DEPTH_4;
      default: depth = DEPTH_NONE;
    endcase
  end

  // Page geometry per depth
  always_comb begin
    case (depth)
      DEPTH_32: begin
        bx       = x[5:3];
        by       = {1'b0, y[4:3]};
        lx       = {1'b0, x[2:0]};
        ly       = {1'b0, y[2:0]};
        page_row = y[10:5];
        page_col = x[10:6];
      end
      DEPTH_16: begin
        bx       = {1'b0, x[5:4]};
        by       = y[5:3];
        lx       = x[3:0];
        ly       = {1'b0, y[2:0]};
        page_row = {1'b0, y[10:6]};
        page_col = x[10:6];
      end
      DEPTH_8: begin
        bx       = x[6:4];
        by       = {1'b0, y[5:4]};
        lx       = x[3:0];
        ly       = y[3:0];
        page_row = {1'b0, y[10:6]};
        page_col = {1'b0, x[10:7]};
      end
      default: begin
        bx       = {1'b0, x[6:5]};
        by       = y[6:4];
        lx       = x[3:0];
        ly       = y[3:0];
        page_row = {2'b00, y[10:7]};
        page_col = {1'b0, x[10:7]};
      end
    endcase
  end

  always_comb begin
    if (depth == DEPTH_8 || depth == DEPTH_4) begin
      across_raw = {1'b0, cfg.buffer_width[5:1]};
    end else begin
      across_raw = cfg.buffer_width;
    end
    across   = (across_raw == '0) ? 6'd1 : across_raw;
    row_base = page_row * across;
    page_low = row_base[8:0] + {4'b0000, page_col};
  end

  // Block inside the page
  always_comb begin
    c32_blk  = {bx[2], by[1], bx[1], by[0], bx[0]};
    c16_blk  = {by[2], bx[1], by[1], bx[0], by[0]};
    c16s_blk = {bx[1], by[1], by[2], bx[0], by[0]};
    case (cfg.pixel_format) inside
      FMT_Z32, FMT_Z24:  blk = c32_blk ^ 5'b11000;
      FMT_CT16, FMT_T4:  blk = c16_blk;
      FMT_CT16S:         blk = c16s_blk;
      FMT_Z16:           blk = c16_blk ^ 5'b11000;
      FMT_Z16S:          blk = c16s_blk ^ 5'b11000;
      default:           blk = c32_blk;
    endcase
    block = cfg.start_block + {page_low, blk};
  end

  // Byte inside the block
  always_comb begin
    case (depth)
      DEPTH_32: byte_off = {ly[2:1], lx[2:1], ly[0], lx[0], 2'b00};
      DEPTH_16: byte_off = {ly[2:1], lx[2:1], ly[0], lx[0], lx[3], 1'b0};
      DEPTH_8:  byte_off = BYTE8[{ly, lx}];
      default:  byte_off = '0;
    endcase
  end

  always_comb begin
    res.bit_offset = '0;
    case (depth)
      DEPTH_NONE: begin
        res.address_valid = 1'b0;
        res.byte_address  = '0;
        res.block_number  = '0;
        res.column_number = '0;
      end
      DEPTH_4: begin
        res.address_valid = 1'b0;
        res.byte_address  = {block, 8'h00};
        res.block_number  = block;
        res.column_number = ly[3:2];
      end
      default: begin
        res.address_valid = 1'b1;
        res.byte_address  = {block, byte_off};
        res.block_number  = block;
        res.column_number = byte_off[7:6];
      end
    endcase
  end

endmodule : spa_addr_calc
`default_nettype wire

FILE: bench/swizzled_pixel_address_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swizzled pixel address checker
// Watches the configuration port and both channels. For every coordinate
// transfer it computes the expected address from its own copy of the
// registers, queues it, and compares each result transfer with the oldest
// expected address. It reports mismatches and results that nothing asked for.
// ----------------------------------------------------------------------------
module swizzled_pixel_address_checker
  import spa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  spa_pixel_if                       pixel,
  spa_result_if                      result,
  output int                         mismatches,
  output int                         outstanding,
  output int                         addresses_seen,
  output int                         full_addresses
);

  localparam int MAX_REPORTS = 10;
  // Z-buffer block tables are the color tables with the upper two block bits flipped.
  localparam logic [4:0] ZBUF_SWAP = 5'b11000;

  cfg_t    settings;
  result_t expected_addresses[$];
  result_t got;
  result_t want;
  int      error_total;
  int      seen_total;
  int      full_total;

  function automatic result_t compute_pixel_address(cfg_t c, logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y);
    result_t     r;
    depth_t      depth;
    int unsigned page_w, page_h, blk_w, blk_h, across, page, blk, bitpos, byte_in_block;
    logic [2:0]  bx, by;
    logic [4:0]  lx, ly;
    logic [4:0]  in_page;
    r = '0;
    case (c.pixel_format)
      FMT_CT32, FMT_CT24, FMT_T8H, FMT_T4HL, FMT_T4HH, FMT_Z32, FMT_Z24: depth = DEPTH_32;
      FMT_CT16, FMT_CT16S, FMT_Z16, FMT_Z16S: depth = DEPTH_16;
      FMT_T8: depth = DEPTH_8;
      FMT_T4: depth = DEPTH_4;
      default: depth = DEPTH_NONE;
    endcase
    case (depth)
      DEPTH_32: begin
        page_w = 64;  page_h = 32;  blk_w = 8;  blk_h = 8;
      end
      DEPTH_16: begin
        page_w = 64;  page_h = 64;  blk_w = 16; blk_h = 8;
      end
      DEPTH_8: begin
        page_w = 128; page_h = 64;  blk_w = 16; blk_h = 16;
      end
      DEPTH_4: begin
        page_w = 128; page_h = 128; blk_w = 32; blk_h = 16;
      end
      default: return r;
    endcase

    across = (c.buffer_width * 64) / page_w;
    if (across == 0) across = 1;
    page = (y / page_h) * across + (x / page_w);
    bx = 3'((x % page_w) / blk_w);
    by = 3'((y % page_h) / blk_h);

    case (c.pixel_format)
      FMT_CT16, FMT_T4: in_page = {by[2], bx[1], by[1], bx[0], by[0]};
      FMT_CT16S:        in_page = {bx[1], by[1], by[2], bx[0], by[0]};
      FMT_Z16:          in_page = {by[2], bx[1], by[1], bx[0], by[0]} ^ ZBUF_SWAP;
      FMT_Z16S:         in_page = {bx[1], by[1], by[2], bx[0], by[0]} ^ ZBUF_SWAP;
      FMT_Z32, FMT_Z24: in_page = {bx[2], by[1], bx[1], by[0], bx[0]} ^ ZBUF_SWAP;
      default:          in_page = {bx[2], by[1], bx[1], by[0], bx[0]};
    endcase

    blk = (c.start_block + page * 32 + in_page) % MEMORY_BLOCKS;
    lx  = 5'(x % blk_w);
    ly  = 5'(y % blk_h);

    if (depth == DEPTH_4) begin
      r.byte_address  = ADDR_W'(blk * BYTES_PER_BLOCK);
      r.block_number  = BLOCK_W'(blk);
      r.column_number = COLUMN_W'(ly / 4);
      return r;
    end

    case (depth)
      DEPTH_32: bitpos = 32 * {ly[2], ly[1], lx[2], lx[1], ly[0], lx[0]};
      DEPTH_16: bitpos = 16 * {ly[2], ly[1], lx[2], lx[1], ly[0], lx[0], lx[3]};
      default:  bitpos = 8 * {ly[3], ly[2], ly[1] ^ lx[2], lx[1], lx[3], lx[0],
                              ly[0] ^ ly[2], ly[1]};
    endcase
    byte_in_block = bitpos >> 3;

    r.address_valid = 1'b1;
    r.byte_address  = ADDR_W'(blk * BYTES_PER_BLOCK + byte_in_block);
    r.bit_offset    = BITOFF_W'(bitpos);
    r.block_number  = BLOCK_W'(blk);
    r.column_number = COLUMN_W'(byte_in_block / 64);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings = '0;
      expected_addresses.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_PIXEL_FORMAT: settings.pixel_format = cfg_data[FORMAT_W-1:0];
          REG_START_BLOCK:  settings.start_block  = cfg_data[BLOCK_W-1:0];
          REG_BUFFER_WIDTH: settings.buffer_width = cfg_data[BWIDTH_W-1:0];
          default: ;
        endcase
      end

      if (pixel.valid && pixel.ready)
        expected_addresses.push_back(
          compute_pixel_address(settings, pixel.pixel_x, pixel.pixel_y));

      if (result.valid && result.ready) begin
        got = '{result.address_valid, result.byte_address, result.bit_offset,
                result.block_number, result.column_number};
        seen_total++;
        if (got.address_valid === 1'b1) full_total++;
        if (expected_addresses.size() == 0) begin
          if (error_total < MAX_REPORTS)
            $display("%0t: result transfer with nothing pending: valid=%0b addr=%h", $time,
                     got.address_valid, got.byte_address);
          error_total++;
        end else begin
          want = expected_addresses.pop_front();
          if (got !== want) begin
            if (error_total < MAX_REPORTS) begin
              $display("%0t: mismatch, expected valid=%0b addr=%h bit=%0d block=%0d col=%0d",
                       $time, want.address_valid, want.byte_address, want.bit_offset,
                       want.block_number, want.column_number);
              $display("%0t: mismatch, got      valid=%0b addr=%h bit=%0d block=%0d col=%0d",
                       $time, got.address_valid, got.byte_address, got.bit_offset,
                       got.block_number, got.column_number);
            end
            error_total++;
          end
        end
      end
    end
    mismatches     <= error_total;
    outstanding    <= expected_addresses.size();
    addresses_seen <= seen_total;
    full_addresses <= full_total;
  end

endmodule : swizzled_pixel_address_checker

FILE: bench/swizzled_pixel_address_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swizzled pixel address testbench
// Drives coordinates through the generator under a series of register
// settings, first a directed set covering every format code, the coordinate
// extremes and the 4-bit and narrow-buffer cases, then random settings with
// random coordinates. Sender bursts and receiver stalls vary throughout; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module swizzled_pixel_address_tb;
  import spa_pkg::*;

  localparam int                    ITEMS_PER_SETTING = 30;
  localparam int                    RANDOM_SETTINGS   = 15;
  localparam int                    SETTLE_CYCLES     = 4;
  localparam int                    RESET_CYCLES      = 7;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE         = 2'd3;
  localparam logic [COORD_W-1:0]    COORD_MAX         = '1;
  localparam logic [BLOCK_W-1:0]    BLOCK_MAX         = '1;
  localparam logic [BWIDTH_W-1:0]   WIDTH_MAX         = '1;

  typedef enum int {RX_OPEN, RX_STALL, RX_HALF, RX_MOSTLY} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spa_pixel_if  pixel_ch ();
  spa_result_if result_ch ();

  int mismatches;
  int outstanding;
  int addresses_seen;
  int full_addresses;
  int transfers_sent;
  int settings_used;
  int burst_left;
  int gap_limit;

  swizzled_pixel_address uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel_ch),
    .result       (result_ch)
  );

  swizzled_pixel_address_checker address_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel          (pixel_ch),
    .result         (result_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .addresses_seen (addresses_seen),
    .full_addresses (full_addresses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rx_mode_t mode;
    int       span;
    result_ch.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = (mode == RX_STALL) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:  result_ch.ready <= 1'b1;
          RX_STALL: result_ch.ready <= 1'b0;
          RX_HALF:  result_ch.ready <= ($urandom_range(0, 1) == 1);
          default:  result_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
  endtask

  // Hold the sender until every result is back, then reprogram all registers.
  task automatic apply_settings(logic [FORMAT_W-1:0] fmt, logic [BLOCK_W-1:0] base,
                                logic [BWIDTH_W-1:0] width);
    pixel_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_PIXEL_FORMAT, {10'($urandom), fmt});
    write_reg(REG_START_BLOCK, base);
    write_reg(REG_BUFFER_WIDTH, {8'($urandom), width});
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_write_en <= 1'b0;
    settings_used++;
    burst_left = $urandom_range(1, 16);
  endtask

  task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    pixel_ch.valid   <= 1'b1;
    pixel_ch.pixel_x <= x;
    pixel_ch.pixel_y <= y;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    transfers_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      if (gap_limit > 0) begin
        pixel_ch.valid <= 1'b0;
        repeat ($urandom_range(1, gap_limit)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  initial begin
    logic [FORMAT_W-1:0] fmt;
    logic [BLOCK_W-1:0]  base;
    logic [BWIDTH_W-1:0] width;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;

    rst              <= 1'b1;
    cfg_write_en     <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    pixel_ch.valid   <= 1'b0;
    pixel_ch.pixel_x <= '0;
    pixel_ch.pixel_y <= '0;
    burst_left       = 4;
    gap_limit        = 3;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at their reset values
    send_pixel('0, '0);
    send_pixel(COORD_MAX, COORD_MAX);

    for (int f = 0; f < 16; f++) begin
      apply_settings(FORMAT_W'(f), f[0] ? BLOCK_MAX : '0, f[0] ? WIDTH_MAX : 6'd1);
      send_pixel(f[1] ? COORD_MAX : '0, f[2] ? COORD_MAX : 11'h555);
    end

    // 4-bit texels: one row from each quarter of the block
    apply_settings(FMT_T4, 14'd100, 6'd2);
    for (int r = 0; r < 4; r++) send_pixel(11'd37, COORD_W'(r * 4 + 1));

    // buffer narrower than one page
    apply_settings(FMT_T8, 14'd5, 6'd1);
    send_pixel(11'd200, 11'd70);

    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      fmt = ($urandom_range(0, 9) == 0) ? FORMAT_W'($urandom_range(13, 15))
                                        : FORMAT_W'($urandom_range(0, 12));
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = BLOCK_MAX;
        default: base = BLOCK_W'($urandom_range(0, BLOCK_MAX));
      endcase
      case ($urandom_range(0, 4))
        0:       width = '0;
        1:       width = WIDTH_MAX;
        2:       width = BWIDTH_W'($urandom_range(1, 2));
        default: width = BWIDTH_W'($urandom_range(0, WIDTH_MAX));
      endcase
      if (s == 0) begin
        base  = BLOCK_MAX;
        width = WIDTH_MAX;
      end else if (s == 1) begin
        base  = '0;
        width = '0;
      end
      gap_limit = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      apply_settings(fmt, base, width);

      repeat (ITEMS_PER_SETTING) begin
        case ($urandom_range(0, 7))
          0: begin
            x = $urandom_range(0, 1) ? COORD_MAX : '0;
            y = $urandom_range(0, 1) ? COORD_MAX : '0;
          end
          1, 2: begin
            x = COORD_W'($urandom_range(0, 255));
            y = COORD_W'($urandom_range(0, 255));
          end
          default: begin
            x = COORD_W'($urandom_range(0, COORD_MAX));
            y = COORD_W'($urandom_range(0, COORD_MAX));
          end
        endcase
        send_pixel(x, y);
      end
    end

    pixel_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);

    $display("Run covered %0d coordinate transfers under %0d register settings.",
             transfers_sent, settings_used);
    $display("Checked %0d results, %0d of them full addresses.", addresses_seen,
             full_addresses);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : swizzled_pixel_address_tb
